### rtl/core/mtfl_pkg.sv
// Shared types and constants for the move-to-front key list.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtfl_pkg;

	localparam int KEY_W    = 32;
	localparam int POS_W    = 9;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

	localparam logic [POS_W-1:0] POS_NONE = '1;

	typedef struct packed {
		logic write_key;
		logic take_left;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SRCH = 2'b10
	} ctl_state_t;

endpackage

`default_nettype wire

### rtl/core/move_to_front_key_list_unit.sv
// Move-to-front key list: an append is accepted with busy low and strobes done in the cycle
// after accept. A search holds busy high until its result is registered, and its done strobe
// follows the key register, $clog2(LIST_DEPTH)+1 registered priority-tree levels, then the
// result register. The next item can be accepted in the done cycle. The receiver cannot
// stall. Reset empties the list.
// Depends on mtfl_pkg, mtfl_cell, mtfl_prio_tree.
`timescale 1ns / 1ps
`default_nettype none

module move_to_front_key_list_unit #(
	parameter int LIST_DEPTH = 256
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                command,
	input  wire logic signed [mtfl_pkg::KEY_W-1:0]   key,
	output logic                                     done,
	output logic signed [mtfl_pkg::POS_W-1:0]        position,
	output logic        [mtfl_pkg::STATUS_W-1:0]     status
);
	import mtfl_pkg::*;

	localparam int LV = $clog2(LIST_DEPTH);
	localparam int CW = $clog2(LIST_DEPTH + 1);
	localparam int WW = $clog2(LV + 2);

	ctl_state_t           state_q;
	logic [WW-1:0]        wait_q;
	logic [CW-1:0]        count_q;
	logic [KEY_W-1:0]     key_q;
	logic                 done_q;
	logic [POS_W-1:0]     pos_q;
	logic [STATUS_W-1:0]  status_q;

	logic                 accept;
	logic                 do_append;
	logic                 room;
	logic                 resolve;
	logic [KEY_W-1:0]     wr_key;
	logic [LIST_DEPTH-1:0] match;
	logic                 hit;
	logic [LV-1:0]        hit_idx;
	logic [KEY_W-1:0]     cell_key [0:LIST_DEPTH-1];
	cell_ctl_t            ctl      [0:LIST_DEPTH-1];

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign do_append = accept && !command;
	assign room      = (count_q < CW'(LIST_DEPTH));
	assign resolve   = (state_q == ST_SRCH) && (wait_q == WW'(LV + 1));
	assign wr_key    = busy ? key_q : key;

	for (genvar j = 0; j < LIST_DEPTH; j++) begin : g_cell
		logic [KEY_W-1:0] left;

		if (j == 0) begin : g_head
			assign left = key_q;
			assign ctl[j].write_key = (do_append && room && count_q == CW'(j))
			                          || (resolve && hit);
			assign ctl[j].take_left = 1'b0;
		end else begin : g_body
			assign left = cell_key[j-1];
			assign ctl[j].write_key = do_append && room && count_q == CW'(j);
			assign ctl[j].take_left = resolve && hit && (LV'(j) <= hit_idx);
		end

		mtfl_cell u_cell (
			.clk      (clk),
			.ctl      (ctl[j]),
			.wr_key   (wr_key),
			.left_key (left),
			.cmp_key  (key_q),
			.occupied (CW'(j) < count_q),
			.key_out  (cell_key[j]),
			.match    (match[j])
		);
	end

	mtfl_prio_tree #(
		.DEPTH (LIST_DEPTH)
	) u_tree (
		.clk   (clk),
		.match (match),
		.found (hit),
		.index (hit_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wait_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (command) begin
							state_q <= ST_SRCH;
							wait_q  <= '0;
						end else begin
							done_q <= 1'b1;
							if (room) begin
								count_q <= count_q + CW'(1);
							end
						end
					end
				end
				ST_SRCH: begin
					wait_q <= wait_q + WW'(1);
					if (resolve) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= key;
		end
		if (do_append) begin
			pos_q    <= POS_NONE;
			status_q <= room ? ST_DONE : ST_FULL;
		end else if (resolve) begin
			pos_q    <= hit ? POS_W'(hit_idx) : POS_NONE;
			status_q <= hit ? ST_DONE : ST_MISSING;
		end
	end

	assign done     = done_q;
	assign position = pos_q;
	assign status   = status_q;

endmodule

`default_nettype wire

### rtl/core/mtfl_cell.sv
// One list cell: holds a key, compares it with the search key, loads
// a new key or its left neighbor's key. Depends on mtfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtfl_cell (
	input  wire logic                      clk,
	input  wire mtfl_pkg::cell_ctl_t       ctl,
	input  wire logic [mtfl_pkg::KEY_W-1:0] wr_key,
	input  wire logic [mtfl_pkg::KEY_W-1:0] left_key,
	input  wire logic [mtfl_pkg::KEY_W-1:0] cmp_key,
	input  wire logic                      occupied,
	output logic      [mtfl_pkg::KEY_W-1:0] key_out,
	output logic                           match
);
	import mtfl_pkg::*;

	logic [KEY_W-1:0] key_q;

	always_ff @(posedge clk) begin
		if (ctl.write_key) begin
			key_q <= wr_key;
		end else if (ctl.take_left) begin
			key_q <= left_key;
		end
	end

	assign key_out = key_q;
	assign match   = occupied && (key_q == cmp_key);

endmodule

`default_nettype wire

### rtl/core/mtfl_prio_tree.sv
// Registered priority tree: finds the lowest-indexed set match bit,
// one tree level per cycle. Depends on mtfl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtfl_prio_tree #(
	parameter int DEPTH = 256
) (
	input  wire logic                       clk,
	input  wire logic [DEPTH-1:0]           match,
	output logic                            found,
	output logic [$clog2(DEPTH)-1:0]        index
);
	import mtfl_pkg::*;

	localparam int LV = $clog2(DEPTH);
	localparam int P  = 1 << LV;

	logic            found_q [0:LV][0:P-1];
	logic [LV-1:0]   idx_q   [0:LV][0:P-1];

	always_ff @(posedge clk) begin
		for (int n = 0; n < P; n++) begin
			found_q[0][n] <= (n < DEPTH) ? match[n] : 1'b0;
			idx_q[0][n]   <= LV'(n);
		end
		for (int l = 1; l <= LV; l++) begin
			for (int n = 0; n < P; n++) begin
				if (n < (P >> l)) begin
					found_q[l][n] <= found_q[l-1][2*n] || found_q[l-1][2*n+1];
					idx_q[l][n]   <= found_q[l-1][2*n] ? idx_q[l-1][2*n]
					                                   : idx_q[l-1][2*n+1];
				end else begin
					found_q[l][n] <= 1'b0;
					idx_q[l][n]   <= '0;
				end
			end
		end
	end

	assign found = found_q[LV][0];
	assign index = idx_q[LV][0];

endmodule

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for move_to_front_key_list_unit: a directed table, then random
// append/search traffic with sender gaps, checked against an in-bench move-to-front list.
// Depends on mtfl_pkg and the unit RTL.
`timescale 1ns / 1ps

module tb_top;
	import mtfl_pkg::*;

	localparam int LIST_DEPTH = 256;
	localparam int RANDOM_ITEMS = 1350;
	localparam int TAIL_CYCLES = 24;
	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	typedef struct packed {
		logic [POS_W-1:0]    pos;
		logic [STATUS_W-1:0] st;
	} result_t;

	typedef struct packed {
		logic             cmd;
		logic [KEY_W-1:0] k;
		logic             typed;
		result_t          res;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                command;
	logic [KEY_W-1:0]    key;
	logic                done;
	logic [POS_W-1:0]    position;
	logic [STATUS_W-1:0] status;

	logic [KEY_W-1:0] list_keys [LIST_DEPTH];
	int               list_len;
	result_t          pending_results [$];
	result_t          oldest;
	int               error_count;
	int               n_append, n_refused, n_hit, n_miss, deepest_hit;

	localparam result_t R_NONE = '{POS_NONE, ST_DONE};
	localparam result_t R_MISS = '{POS_NONE, ST_MISSING};

	stim_row_t directed_rows [14] = '{
		'{CMD_SEARCH, 32'h0000_0000, 1'b1, R_MISS},
		'{CMD_SEARCH, 32'h7FFF_FFFF, 1'b1, R_MISS},
		'{CMD_APPEND, 32'h8000_0000, 1'b1, R_NONE},
		'{CMD_APPEND, 32'h7FFF_FFFF, 1'b1, R_NONE},
		'{CMD_APPEND, 32'h0000_0000, 1'b1, R_NONE},
		'{CMD_APPEND, 32'hFFFF_FFFF, 1'b1, R_NONE},
		'{CMD_APPEND, 32'h7FFF_FFFF, 1'b1, R_NONE},
		'{CMD_SEARCH, 32'h8000_0000, 1'b1, '{9'd0, ST_DONE}},
		'{CMD_SEARCH, 32'hFFFF_FFFF, 1'b0, R_NONE},
		'{CMD_SEARCH, 32'h7FFF_FFFF, 1'b0, R_NONE},
		'{CMD_SEARCH, 32'h1234_5678, 1'b1, R_MISS},
		'{CMD_SEARCH, 32'h0000_0000, 1'b0, R_NONE},
		'{CMD_APPEND, 32'h5555_AAAA, 1'b1, R_NONE},
		'{CMD_SEARCH, 32'h5555_AAAA, 1'b0, R_NONE}
	};

	move_to_front_key_list_unit #(
		.LIST_DEPTH(LIST_DEPTH)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.command (command),
		.key     (key),
		.done    (done),
		.position(position),
		.status  (status)
	);

	always #5 clk = ~clk;

	function automatic result_t mtf_predict(input logic cmd, input logic [KEY_W-1:0] k);
		result_t r;
		int      hit;
		r.pos = POS_NONE;
		r.st = ST_DONE;
		if (cmd == CMD_APPEND) begin
			if (list_len >= LIST_DEPTH) begin
				r.st = ST_FULL;
				n_refused++;
			end else begin
				list_keys[list_len] = k;
				list_len++;
				n_append++;
			end
		end else begin
			hit = -1;
			for (int i = 0; i < list_len; i++)
				if (hit < 0 && list_keys[i] == k)
					hit = i;
			if (hit < 0) begin
				r.st = ST_MISSING;
				n_miss++;
			end else begin
				for (int j = hit; j > 0; j--)
					list_keys[j] = list_keys[j-1];
				list_keys[0] = k;
				r.pos = hit[POS_W-1:0];
				n_hit++;
				if (hit > deepest_hit)
					deepest_hit = hit;
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	task automatic send_item(input logic cmd, input logic [KEY_W-1:0] k, input logic typed,
			input result_t typed_res);
		result_t res;
		@(negedge clk);
		start = 1'b1;
		command = cmd;
		key = k;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		res = mtf_predict(cmd, k);
		pending_results.push_back(typed ? typed_res : res);
	endtask

	task automatic idle_cycles(input int n);
		@(negedge clk);
		start = 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending: pos %h code %h",
					position, status));
			end else begin
				oldest = pending_results.pop_front();
				if (position !== oldest.pos)
					report_mismatch($sformatf("position got %h want %h", position, oldest.pos));
				if (status !== oldest.st)
					report_mismatch($sformatf("result code got %h want %h", status, oldest.st));
			end
		end
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d results pending", pending_results.size());
		$display("status: fail");
		$finish;
	end

	initial begin
		logic [KEY_W-1:0] k;
		logic             cmd;
		int               append_pct;
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		command = CMD_APPEND;
		key = '0;
		list_len = 0;
		error_count = 0;
		n_append = 0;
		n_refused = 0;
		n_hit = 0;
		n_miss = 0;
		deepest_hit = -1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i].cmd, directed_rows[i].k, directed_rows[i].typed,
				directed_rows[i].res);
		wait_drained();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 450 || n == 900)
				wait_drained();
			append_pct = (n < 450) ? 55 : 20;
			cmd = ($urandom_range(0, 99) < append_pct) ? CMD_APPEND : CMD_SEARCH;
			if (cmd == CMD_SEARCH && list_len > 0 && $urandom_range(0, 3) != 0) begin
				if ($urandom_range(0, 3) == 0)
					k = list_keys[list_len - 1];
				else
					k = list_keys[$urandom_range(0, list_len - 1)];
			end else begin
				case ($urandom_range(0, 3))
					0: k = $urandom_range(0, 8) - 4;
					1: begin
						case ($urandom_range(0, 3))
							0: k = 32'h8000_0000;
							1: k = 32'h7FFF_FFFF;
							2: k = 32'h0000_0000;
							default: k = 32'hFFFF_FFFF;
						endcase
					end
					default: k = $urandom;
				endcase
			end
			send_item(cmd, k, 1'b0, R_NONE);
			if (n < RANDOM_ITEMS - 200 && (n / 100) % 3 != 2 && $urandom_range(0, 3) == 0)
				idle_cycles($urandom_range(1, 9));
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("ran %0d appends (%0d refused on a full list) and %0d searches",
			n_append + n_refused, n_refused, n_hit + n_miss);
		$display("searches: %0d hits, %0d misses, deepest hit %0d; final length %0d",
			n_hit, n_miss, deepest_hit, list_len);
		if (error_count == 0 && pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
